// File: src/sld_pkg.sv
// Shared constants, types and helpers for the server load dispatcher.
package sld_pkg;

  // Server count and derived widths.
  localparam int SERVERS = 128;
  localparam int IDX_W   = $clog2(SERVERS);
  localparam int CNT_W   = $clog2(SERVERS + 1);
  localparam int CW      = 16;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  // Event codes.
  localparam logic [1:0] FUNC_DISPATCH = 2'd0;
  localparam logic [1:0] FUNC_START    = 2'd1;
  localparam logic [1:0] FUNC_DONE     = 2'd2;

  // Dispatch modes.
  localparam logic [2:0] MODE_RANDOM     = 3'd0;
  localparam logic [2:0] MODE_CYCLIC     = 3'd1;
  localparam logic [2:0] MODE_SCAN       = 3'd2;
  localparam logic [2:0] MODE_TWO_RANDOM = 3'd3;
  localparam logic [2:0] MODE_CYC_RANDOM = 3'd4;

  // Counts of one server.
  typedef struct packed {
    logic [CW-1:0] waiting;
    logic [CW-1:0] occupancy;
  } entry_t;

  // Control from the sequencer to the candidate compare unit.
  typedef struct packed {
    logic take;
    logic first;
    logic scan_rule;
  } sel_ctrl_t;

  // Reduce a 7-bit index field modulo the server count.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [6:0] v);
    return IDX_W'(int'(v) % SERVERS);
  endfunction

endpackage

// File: src/server_load_dispatcher.sv
// Server load dispatcher: per-server counters, dispatch sequencer and result register.
// Accept to result runs through the read, drain and update states, with one counter-memory
// read per server in the read state: one for single-read events, two for two-choice modes
// and every server for the shortest-queue scan, through a single read port. One item is in
// work at a time; the next is taken the cycle after write-back, and an unread result
// holds the write-back. Reset (rst, synchronous) clears all counters through per-server
// valid bits at once, the cyclic position and the dispatch mode.
module server_load_dispatcher import sld_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [6:0]  server_index,
  input  logic [6:0]  random_first,
  input  logic [6:0]  random_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  chosen_server,
  output logic [15:0] waiting_now,
  output logic [15:0] occupancy_now,
  output logic        fault
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]       state;
  logic [2:0]       dispatch_mode;
  logic [IDX_W-1:0] cyclic_position;
  logic [1:0]       func_q;
  logic [IDX_W-1:0] addr_a;
  logic [IDX_W-1:0] addr_b;
  logic [CNT_W-1:0] n_reads;
  logic [CNT_W-1:0] cnt;
  logic             scan;
  logic             pend;
  logic             pend_first;
  logic [IDX_W-1:0] pend_idx;
  logic             rd_vld;
  logic [SERVERS-1:0] vld;

  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic [2*CW-1:0]  rd_data;
  logic             wr_en;
  entry_t           wr_entry;
  entry_t           in_entry;
  entry_t           cand_entry;
  logic [IDX_W-1:0] cand_idx;
  sel_ctrl_t        sel_ctrl;
  logic             upd_fault;
  logic             accept;
  logic             out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Read address: the scan walks every server, otherwise one or two chosen servers.
  always_comb begin
    if (scan) begin
      rd_addr = cnt[IDX_W-1:0];
    end else if (cnt == '0) begin
      rd_addr = addr_a;
    end else begin
      rd_addr = addr_b;
    end
  end

  assign rd_en    = (state == ST_READ);
  assign in_entry = rd_vld ? entry_t'(rd_data) : '0;

  // Control for the shared compare unit.
  always_comb begin
    sel_ctrl.take      = pend;
    sel_ctrl.first     = pend_first;
    sel_ctrl.scan_rule = scan;
  end

  sld_ram #(
    .WIDTH(2 * CW),
    .DEPTH(SERVERS)
  ) u_counts (
    .clk  (clk),
    .we   (wr_en),
    .waddr(cand_idx),
    .wdata(wr_entry),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  sld_select u_select (
    .clk       (clk),
    .ctrl      (sel_ctrl),
    .in_idx    (pend_idx),
    .in_entry  (in_entry),
    .cand_idx  (cand_idx),
    .cand_entry(cand_entry)
  );

  // Counter update for the chosen server.
  always_comb begin
    wr_entry  = cand_entry;
    upd_fault = 1'b0;
    unique case (func_q)
      FUNC_DISPATCH: begin
        if (cand_entry.waiting == COUNT_MAX) begin
          upd_fault = 1'b1;
        end else begin
          wr_entry.waiting = cand_entry.waiting + 1'b1;
        end
        if (cand_entry.occupancy == COUNT_MAX) begin
          upd_fault = 1'b1;
        end else begin
          wr_entry.occupancy = cand_entry.occupancy + 1'b1;
        end
      end
      FUNC_START: begin
        if (cand_entry.waiting == '0) begin
          upd_fault = 1'b1;
        end else begin
          wr_entry.waiting = cand_entry.waiting - 1'b1;
        end
      end
      FUNC_DONE: begin
        if (cand_entry.occupancy == '0) begin
          upd_fault = 1'b1;
        end else begin
          wr_entry.occupancy = cand_entry.occupancy - 1'b1;
        end
      end
      default: begin
        wr_entry  = cand_entry;
        upd_fault = 1'b0;
      end
    endcase
  end

  assign wr_en = (state == ST_UPDATE) && out_free;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      dispatch_mode   <= MODE_RANDOM;
      cyclic_position <= '0;
      pend            <= 1'b0;
      vld             <= '0;
    end else begin
      if (cfg_we) begin
        dispatch_mode <= cfg_data;
      end
      pend <= rd_en;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (cnt + 1'b1 == n_reads) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            vld[cand_idx] <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (accept && func == FUNC_DISPATCH) begin
        if (cyclic_position == IDX_W'(SERVERS - 1)) begin
          cyclic_position <= '0;
        end else begin
          cyclic_position <= cyclic_position + 1'b1;
        end
      end
    end
  end

  // Item capture, read counter and read tags.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= func;
      cnt     <= '0;
      scan    <= 1'b0;
      addr_b  <= '0;
      n_reads <= CNT_W'(1);
      if (func == FUNC_DISPATCH) begin
        unique case (dispatch_mode)
          MODE_RANDOM: begin
            addr_a <= wrap_idx(random_first);
          end
          MODE_CYCLIC: begin
            addr_a <= cyclic_position;
          end
          MODE_SCAN: begin
            addr_a  <= '0;
            scan    <= 1'b1;
            n_reads <= CNT_W'(SERVERS);
          end
          MODE_TWO_RANDOM: begin
            addr_a  <= wrap_idx(random_first);
            addr_b  <= wrap_idx(random_second);
            n_reads <= CNT_W'(2);
          end
          MODE_CYC_RANDOM: begin
            addr_a  <= cyclic_position;
            addr_b  <= wrap_idx(random_first);
            n_reads <= CNT_W'(2);
          end
          default: begin
            addr_a <= '0;
          end
        endcase
      end else begin
        addr_a <= wrap_idx(server_index);
      end
    end else if (rd_en) begin
      cnt <= cnt + 1'b1;
    end
    pend_first <= (cnt == '0);
    pend_idx   <= rd_addr;
    rd_vld     <= vld[rd_addr];
  end

  // Result register, free to hold a result while the next item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      chosen_server <= 7'(cand_idx);
      waiting_now   <= wr_entry.waiting;
      occupancy_now <= wr_entry.occupancy;
      fault         <= upd_fault;
    end
  end

endmodule

// File: src/sld_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/sld_select.sv
// Shared compare unit that keeps the current candidate server and its counts.
module sld_select import sld_pkg::*; (
  input  logic             clk,
  input  sel_ctrl_t        ctrl,
  input  logic [IDX_W-1:0] in_idx,
  input  entry_t           in_entry,
  output logic [IDX_W-1:0] cand_idx,
  output entry_t           cand_entry
);

  logic replace;

  // Decide whether the arriving server replaces the candidate.
  always_comb begin
    if (ctrl.first) begin
      replace = 1'b1;
    end else if (ctrl.scan_rule) begin
      replace = (in_entry.occupancy < cand_entry.occupancy) &&
                (in_entry.waiting < cand_entry.waiting);
    end else begin
      replace = !(cand_entry.occupancy < in_entry.occupancy);
    end
  end

  // Candidate register.
  always_ff @(posedge clk) begin
    if (ctrl.take && replace) begin
      cand_idx   <= in_idx;
      cand_entry <= in_entry;
    end
  end

endmodule
